FILE: design/cld_pkg.sv
// shared constants for the command/length packet deframer
package cld_pkg;

  localparam logic [1:0]  ST_OK          = 2'd0;
  localparam logic [1:0]  ST_LONG        = 2'd1;
  localparam logic [1:0]  ST_SHORT       = 2'd2;

  localparam logic [15:0] MIN_DECLARED   = 16'd3;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd4096;

  // register word index, taken from paddr[2]
  localparam logic        REG_MAX_LENGTH = 1'b0;

endpackage

FILE: design/command_length_packet_deframer.sv
// command/length packet deframer: splits a byte stream into tagged packet bytes
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   req_type, data_byte, table_index, table_length
//  out_     output     out_valid/out_stall byte, command, offset, length, last, status
//  cfg_     apb slave  psel/penable/pready max_length at byte address 0
//
// one item per cycle sustained while out_stall is low; a data byte passes from stage one to the output register
// the length table read is registered at accept time (stage one), framing is done
// between stage one and the output register
// table writes take effect at their accept edge and give no result
// reset clears control state and the table's valid bits at once, so no clearing pass
// out_stall holds the output register; stage one still accepts until it is full

module command_length_packet_deframer
  import cld_pkg::*;
#(
  parameter int COMMAND_CODES = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_table_index,
  input  logic [15:0] in_table_length,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_packet_command,
  output logic [15:0] out_byte_offset,
  output logic [15:0] out_packet_length,
  output logic        out_last_of_packet,
  output logic [1:0]  out_status,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int         AW    = (COMMAND_CODES > 1) ? $clog2(COMMAND_CODES) : 1;
  localparam logic [8:0] CODES = 9'(COMMAND_CODES);

  typedef enum logic [1:0] {PH_IDLE, PH_LEN_HI, PH_LEN_LO, PH_BODY} phase_t;

  // ---------------------------------------------------------------- config
  logic [15:0] max_len_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_LENGTH) ? {16'd0, max_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_MAX_LENGTH) begin
      max_len_r <= cfg_pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------- handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  // stage one moves when the output register is empty or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------- length table
  logic [15:0]              tbl_mem [COMMAND_CODES];
  logic [COMMAND_CODES-1:0] tbl_vld_r;
  logic                     wr_ok;
  logic                     rd_ok;
  logic [AW-1:0]            wr_idx;
  logic [AW-1:0]            rd_idx;

  // codes past the table depth are not stored and read as variable length
  assign wr_ok  = ({1'b0, in_table_index} < CODES);
  assign rd_ok  = ({1'b0, in_data_byte} < CODES);
  assign wr_idx = in_table_index[AW-1:0];
  assign rd_idx = in_data_byte[AW-1:0];

  logic [15:0] s1_rd_r;
  logic        s1_hit_r;
  logic [7:0]  s1_byte_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_req_type && wr_ok) begin
      tbl_mem[wr_idx] <= in_table_length;
    end
    if (in_acc && !in_req_type) begin
      s1_rd_r   <= tbl_mem[rd_idx];
      s1_byte_r <= in_data_byte;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      s1_hit_r  <= 1'b0;
    end else begin
      if (in_acc && in_req_type && wr_ok) begin
        tbl_vld_r[wr_idx] <= 1'b1;
      end
      if (in_acc && !in_req_type) begin
        s1_hit_r <= rd_ok && tbl_vld_r[rd_idx];
      end
    end
  end

  // ---------------------------------------------------------------- framing
  phase_t      phase_r,  phase_nxt;
  logic [7:0]  cmd_r,    cmd_nxt;
  logic [15:0] total_r,  total_nxt;
  logic [15:0] seen_r,   seen_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;

  logic [15:0] s1_len;
  logic [15:0] decl_len;
  logic [15:0] seen_inc;
  logic [15:0] off_nxt;
  logic [15:0] plen_nxt;
  logic        last_nxt;
  logic [1:0]  st_nxt;

  assign s1_len   = s1_hit_r ? s1_rd_r : 16'd0;
  assign decl_len = {len_hi_r, s1_byte_r};
  assign seen_inc = seen_r + 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    total_nxt  = total_r;
    seen_nxt   = seen_r;
    len_hi_nxt = len_hi_r;
    off_nxt    = 16'd0;
    plen_nxt   = 16'd0;
    last_nxt   = 1'b0;
    st_nxt     = ST_OK;
    unique case (phase_r)
      PH_IDLE: begin
        cmd_nxt  = s1_byte_r;
        plen_nxt = s1_len;
        // zero entry: length follows in two bytes
        priority if (s1_len == 16'd0) begin
          phase_nxt = PH_LEN_HI;
        end else if (s1_len > max_len_r) begin
          last_nxt = 1'b1;
          st_nxt   = ST_LONG;
        end else if (s1_len == 16'd1) begin
          last_nxt = 1'b1;
        end else begin
          total_nxt = s1_len;
          seen_nxt  = 16'd1;
          phase_nxt = PH_BODY;
        end
      end
      PH_LEN_HI: begin
        len_hi_nxt = s1_byte_r;
        off_nxt    = 16'd1;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        off_nxt  = 16'd2;
        plen_nxt = decl_len;
        // too long is checked ahead of too short
        priority if (decl_len > max_len_r) begin
          phase_nxt = PH_IDLE;
          last_nxt  = 1'b1;
          st_nxt    = ST_LONG;
        end else if (decl_len < MIN_DECLARED) begin
          phase_nxt = PH_IDLE;
          last_nxt  = 1'b1;
          st_nxt    = ST_SHORT;
        end else if (decl_len == MIN_DECLARED) begin
          phase_nxt = PH_IDLE;
          last_nxt  = 1'b1;
        end else begin
          total_nxt = decl_len;
          seen_nxt  = 16'd3;
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        off_nxt  = seen_r;
        plen_nxt = total_r;
        seen_nxt = seen_inc;
        last_nxt = (seen_inc >= total_r);
        if (last_nxt) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- state and result register
  logic [7:0]  out_byte_r;
  logic [7:0]  out_cmd_r;
  logic [15:0] out_off_r;
  logic [15:0] out_plen_r;
  logic        out_last_r;
  logic [1:0]  out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      cmd_r       <= 8'd0;
      total_r     <= 16'd0;
      seen_r      <= 16'd0;
      len_hi_r    <= 8'd0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= !in_req_type;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        phase_r    <= phase_nxt;
        cmd_r      <= cmd_nxt;
        total_r    <= total_nxt;
        seen_r     <= seen_nxt;
        len_hi_r   <= len_hi_nxt;
        out_byte_r <= s1_byte_r;
        out_cmd_r  <= cmd_nxt;
        out_off_r  <= off_nxt;
        out_plen_r <= plen_nxt;
        out_last_r <= last_nxt;
        out_st_r   <= st_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_packet_command = out_cmd_r;
  assign out_byte_offset    = out_off_r;
  assign out_packet_length  = out_plen_r;
  assign out_last_of_packet = out_last_r;
  assign out_status         = out_st_r;

  // ---------------------------------------------------------------- checks
  // any error ends the packet
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last_of_packet)
    else $error("error status without last_of_packet");

  // a too-short length can only come from the declared length bytes
  a_short_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SHORT |-> out_byte_offset == 16'd2)
    else $error("too-short status away from the length low byte");

  // a last byte always sends framing back to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && last_nxt |=> phase_r == PH_IDLE)
    else $error("framing not idle after last byte");

  // input is held off only while stage one is full and blocked
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipe");

endmodule
